// File: hw/rtl/tour_length_fitness_evaluator_assert.svh
// Assertion macros for the tour length fitness evaluator checker.
// Each macro expands to one labeled concurrent assertion on a rising clock edge.
`ifndef TOUR_LENGTH_FITNESS_EVALUATOR_ASSERT_SVH
`define TOUR_LENGTH_FITNESS_EVALUATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define TLFE_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("tlfe: same-cycle check failed");

// next-cycle implication, disabled while reset is held
`define TLFE_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("tlfe: next-cycle check failed");

`endif

// File: hw/rtl/tlfe_pkg.sv
// Shared constants, field widths and controller/datapath command types.
// No dependencies.
`default_nettype none

package tlfe_pkg;

  localparam int MAX_CITIES_DEF = 64;
  localparam int DIST_BITS_DEF  = 24;

  localparam int CITY_W    = 6;
  localparam int DIST_IN_W = 24;
  localparam int COUNT_W   = 7;
  localparam int LEN_W     = 30;
  localparam int FIT_W     = 32;

  localparam int CITY_COUNT_RST = 64;
  localparam int FRAC_ONE       = 256;
  localparam int DIV_STEPS      = 40;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CITY  = 1'b1;

  typedef struct packed {
    logic mem_wr;
    logic city_take;
    logic city_first;
    logic leg_add;
    logic close_rd;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/tlfe_in_if.sv
// Input channel: valid/ready handshake with the matrix write and tour city fields.
// Depends on tlfe_pkg.
`default_nettype none

interface tlfe_in_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [tlfe_pkg::CITY_W-1:0]    row_city;
  logic [tlfe_pkg::CITY_W-1:0]    col_city;
  logic [tlfe_pkg::DIST_IN_W-1:0] dist_value;
  logic [tlfe_pkg::CITY_W-1:0]    city;

  modport source (output valid, opcode, row_city, col_city, dist_value, city,
                  input ready);
  modport sink   (input valid, opcode, row_city, col_city, dist_value, city,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tlfe_out_if.sv
// Result channel: valid/ready handshake with tour length and fitness.
// Depends on tlfe_pkg.
`default_nettype none

interface tlfe_out_if;
  logic                       valid;
  logic                       ready;
  logic [tlfe_pkg::LEN_W-1:0] tour_length;
  logic [tlfe_pkg::FIT_W-1:0] fitness;

  modport source (output valid, tour_length, fitness, input ready);
  modport sink   (input valid, tour_length, fitness, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tour_length_fitness_evaluator.sv
// Closed tour length and fitness evaluator: tlfe_ctrl sequences tlfe_dpath.
// Write word and first tour city: handled in ST_IDLE. Other cities also pass ST_LEG
// (matrix read and add). Closing city: return leg, 40-step bit-serial divide, then
// the result word is registered once the output register is free; the next word is
// taken then. Reset clears control state, sets city_count to 64; the distance
// matrix is not cleared. Depends on tlfe_pkg, tlfe_in_if, tlfe_out_if.
`default_nettype none

module tour_length_fitness_evaluator #(
  parameter int MAX_CITIES = tlfe_pkg::MAX_CITIES_DEF,
  parameter int DIST_BITS  = tlfe_pkg::DIST_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [tlfe_pkg::COUNT_W-1:0] cfg_wdata,
  tlfe_in_if.sink                           in_ch,
  tlfe_out_if.source                        out_ch
);

  tlfe_pkg::cmd_t cmd;
  tlfe_pkg::sts_t sts;
  logic           ctl_ready;

  tlfe_ctrl #(
    .MAX_CITIES (MAX_CITIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (ctl_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tlfe_dpath #(
    .MAX_CITIES (MAX_CITIES),
    .DIST_BITS  (DIST_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_row_city   (in_ch.row_city),
    .in_col_city   (in_ch.col_city),
    .in_dist_value (in_ch.dist_value),
    .in_city       (in_ch.city),
    .out_ch        (out_ch)
  );

  assign in_ch.ready = ctl_ready;

endmodule

`default_nettype wire

// File: hw/rtl/tlfe_ctrl.sv
// Controller: city_count register, tour position counter and sequencing FSM.
// Depends on tlfe_pkg; drives the datapath through cmd_t.
`default_nettype none

module tlfe_ctrl #(
  parameter int MAX_CITIES = tlfe_pkg::MAX_CITIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [tlfe_pkg::COUNT_W-1:0] cfg_wdata,
  input  wire logic                         in_valid,
  input  wire logic                         in_opcode,
  output logic                              in_ready,
  input  wire tlfe_pkg::sts_t               sts,
  output tlfe_pkg::cmd_t                    cmd
);

  localparam int CNT_W   = $clog2(MAX_CITIES + 1);
  localparam int CL_W    = (CNT_W > tlfe_pkg::COUNT_W) ? CNT_W : tlfe_pkg::COUNT_W;
  localparam int CNT_RST = (tlfe_pkg::CITY_COUNT_RST < MAX_CITIES) ?
                           tlfe_pkg::CITY_COUNT_RST : MAX_CITIES;
  localparam int STEP_W  = $clog2(tlfe_pkg::DIV_STEPS);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LEG   = 6'b000010,
    ST_CLOSE = 6'b000100,
    ST_PREP  = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_HOLD  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  seen_r, seen_nxt;
  logic              last_r, last_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  logic [CL_W-1:0]   cfg_ext;
  logic [CNT_W-1:0]  seen_inc;
  logic              accept;
  logic              closing;

  always_comb begin
    cfg_ext   = CL_W'(cfg_wdata);
    count_nxt = count_r;
    if (cfg_we) begin
      if (cfg_ext < CL_W'(2)) begin
        count_nxt = CNT_W'(2);
      end else if (cfg_ext > CL_W'(MAX_CITIES)) begin
        count_nxt = CNT_W'(MAX_CITIES);
      end else begin
        count_nxt = CNT_W'(cfg_ext);
      end
    end
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    accept    = in_valid && in_ready;
    seen_inc  = seen_r + CNT_W'(1);
    closing   = (seen_inc >= count_r);
    cmd       = '0;
    state_nxt = state_r;
    seen_nxt  = seen_r;
    last_nxt  = last_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode == tlfe_pkg::OP_WRITE) begin
            cmd.mem_wr = 1'b1;
          end else begin
            cmd.city_take = 1'b1;
            if (seen_r == '0) begin
              cmd.city_first = 1'b1;
              seen_nxt       = CNT_W'(1);
            end else begin
              last_nxt  = closing;
              seen_nxt  = closing ? '0 : seen_inc;
              state_nxt = ST_LEG;
            end
          end
        end
      end
      ST_LEG: begin
        cmd.leg_add  = 1'b1;
        cmd.close_rd = 1'b1;
        state_nxt    = last_r ? ST_CLOSE : ST_IDLE;
      end
      ST_CLOSE: begin
        cmd.leg_add = 1'b1;
        state_nxt   = ST_PREP;
      end
      ST_PREP: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(tlfe_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= CNT_W'(CNT_RST);
      seen_r  <= '0;
      last_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      seen_r  <= seen_nxt;
      last_r  <= last_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tlfe_dpath.sv
// Datapath: distance matrix memory, running length, restoring divider, output register.
// Depends on tlfe_pkg and tlfe_out_if; steered by cmd_t from tlfe_ctrl.
`default_nettype none

module tlfe_dpath #(
  parameter int MAX_CITIES = tlfe_pkg::MAX_CITIES_DEF,
  parameter int DIST_BITS  = tlfe_pkg::DIST_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire tlfe_pkg::cmd_t                 cmd,
  output tlfe_pkg::sts_t                      sts,
  input  wire logic [tlfe_pkg::CITY_W-1:0]    in_row_city,
  input  wire logic [tlfe_pkg::CITY_W-1:0]    in_col_city,
  input  wire logic [tlfe_pkg::DIST_IN_W-1:0] in_dist_value,
  input  wire logic [tlfe_pkg::CITY_W-1:0]    in_city,
  tlfe_out_if.source                          out_ch
);

  localparam int CW     = $clog2(MAX_CITIES);
  localparam int ADDR_W = 2 * CW;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int LEN_W  = tlfe_pkg::LEN_W;
  localparam int FIT_W  = tlfe_pkg::FIT_W;
  localparam int SUM_W  = ((DIST_BITS > LEN_W) ? DIST_BITS : LEN_W) + 1;
  localparam int DEN_W  = LEN_W + 1;

  function automatic logic [CW-1:0] wrap_city(input logic [tlfe_pkg::CITY_W-1:0] v);
    logic [CW-1:0] w;
    w = '0;
    for (int i = 0; i < (1 << tlfe_pkg::CITY_W); i++) begin
      if (v == tlfe_pkg::CITY_W'(i)) begin
        w = CW'(i % MAX_CITIES);
      end
    end
    return w;
  endfunction

  logic [DIST_BITS-1:0] mem [DEPTH];
  logic [DIST_BITS-1:0] rd_r;
  logic [CW-1:0]        first_r;
  logic [CW-1:0]        prev_r;
  logic [LEN_W-1:0]     run_r, run_nxt;
  logic [DEN_W-1:0]     den_r;
  logic [DEN_W-1:0]     rem_r;
  logic [FIT_W-1:0]     quo_r;
  logic                 out_valid_r;
  logic [LEN_W-1:0]     out_len_r;
  logic [FIT_W-1:0]     out_fit_r;

  logic [CW-1:0]        row_w, col_w, city_w;
  logic [ADDR_W-1:0]    rd_addr, wr_addr;
  logic [SUM_W-1:0]     sum;
  logic [DEN_W:0]       rem_sh, rem_dif, den_ext;
  logic                 q_bit;
  logic [FIT_W-1:0]     fit;

  always_comb begin
    row_w   = wrap_city(in_row_city);
    col_w   = wrap_city(in_col_city);
    city_w  = wrap_city(in_city);
    wr_addr = {row_w, col_w};
    rd_addr = cmd.close_rd ? {prev_r, first_r} : {prev_r, city_w};

    sum = SUM_W'(run_r) + SUM_W'(rd_r);
    if (sum > SUM_W'(tlfe_pkg::LEN_MAX)) begin
      run_nxt = tlfe_pkg::LEN_MAX;
    end else begin
      run_nxt = LEN_W'(sum);
    end

    rem_sh  = {rem_r, 1'b0};
    den_ext = {1'b0, den_r};
    q_bit   = (rem_sh >= den_ext);
    rem_dif = rem_sh - den_ext;

    fit = (run_r == '0) ? '1 : quo_r;

    sts.out_busy = out_valid_r && !out_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[wr_addr] <= DIST_BITS'(in_dist_value);
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.city_take) begin
      prev_r <= city_w;
      if (cmd.city_first) begin
        first_r <= city_w;
      end
    end
    if (cmd.city_first) begin
      run_r <= '0;
    end else if (cmd.leg_add) begin
      run_r <= run_nxt;
    end
    if (cmd.div_init) begin
      den_r <= DEN_W'(run_r) + DEN_W'(tlfe_pkg::FRAC_ONE);
      rem_r <= DEN_W'(1);
      quo_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? DEN_W'(rem_dif) : DEN_W'(rem_sh);
      quo_r <= {quo_r[FIT_W-2:0], q_bit};
    end
    if (cmd.out_load) begin
      out_len_r <= run_r;
      out_fit_r <= fit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.tour_length = out_len_r;
  assign out_ch.fitness     = out_fit_r;

endmodule

`default_nettype wire

// File: hw/rtl/tlfe_checker.sv
// Port-level checker for tour_length_fitness_evaluator, attached by bind.
// Depends on tlfe_pkg and tour_length_fitness_evaluator_assert.svh.
`default_nettype none

`include "tour_length_fitness_evaluator_assert.svh"

module tlfe_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [tlfe_pkg::LEN_W-1:0] out_tour_length,
  input wire logic [tlfe_pkg::FIT_W-1:0] out_fitness
);

  `TLFE_ASSERT_NXT(a_out_valid_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `TLFE_ASSERT_NXT(a_out_word_hold, clk, rst_n, out_valid && !out_ready, $stable(out_tour_length) && $stable(out_fitness))
  `TLFE_ASSERT_IMP(a_fit_sat, clk, rst_n, out_valid, (out_tour_length == '0) == (out_fitness == '1))
  `TLFE_ASSERT_NXT(a_no_result_after_take, clk, rst_n, in_valid && in_ready, !$rose(out_valid))

endmodule

bind tour_length_fitness_evaluator tlfe_checker u_tlfe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_tour_length (out_ch.tour_length),
  .out_fitness     (out_ch.fitness)
);

`default_nettype wire

// File: verif/tour_length_fitness_evaluator_tb.sv
// Self-checking testbench for tour_length_fitness_evaluator: matrix writes and tour
// cities go in, closed tour lengths and fitness words are predicted and compared.
// Depends on tlfe_pkg, tlfe_in_if, tlfe_out_if and the evaluator RTL.
`timescale 1ns / 1ps

module tour_length_fitness_evaluator_tb;
  import tlfe_pkg::*;

  typedef struct packed {
    logic                 opcode;
    logic [CITY_W-1:0]    row_city;
    logic [CITY_W-1:0]    col_city;
    logic [DIST_IN_W-1:0] dist_value;
    logic [CITY_W-1:0]    city;
  } tour_word_t;

  typedef struct packed {
    logic [LEN_W-1:0] tour_length;
    logic [FIT_W-1:0] fitness;
  } tour_score_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [COUNT_W-1:0]   cfg_wdata;

  tlfe_in_if  in_ch();
  tlfe_out_if out_ch();

  tour_length_fitness_evaluator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  tour_word_t  pending_words[$];
  tour_score_t expected_scores[$];
  int unsigned fail_count;
  int unsigned words_planned;
  int unsigned city_count_cfg;
  bit          in_burst;
  bit          out_burst;

  // predictor state
  logic [DIST_IN_W-1:0] dist_mat [64][64];
  int unsigned          tour_seen;
  logic [CITY_W-1:0]    tour_first;
  logic [CITY_W-1:0]    tour_prev;
  longint unsigned      tour_len;

  // stimulus planning state
  bit                   plan_written [64][64];
  int unsigned          plan_seen;
  logic [CITY_W-1:0]    plan_first;
  logic [CITY_W-1:0]    plan_prev;

  tour_word_t  cur_word;
  bit          in_took;
  int unsigned in_gap;
  int unsigned ready_hold;

  always #4 clk = ~clk;

  task automatic report_fail(input string what);
    $display("ERROR at %0t: %s", $time, what);
    fail_count++;
  endtask

  function automatic int unsigned pick_gap(input bit burst);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic longint unsigned add_sat(input longint unsigned a,
                                              input longint unsigned b);
    longint unsigned sum;
    sum = a + b;
    return (sum > LEN_MAX) ? longint'(LEN_MAX) : sum;
  endfunction

  task automatic score_word(input tour_word_t w);
    logic [CITY_W-1:0] c;
    longint unsigned   total;
    longint unsigned   fit;
    tour_score_t       s;
    if (w.opcode == OP_WRITE) begin
      dist_mat[w.row_city][w.col_city] = w.dist_value;
    end else begin
      c = w.city;
      if (tour_seen == 0) begin
        tour_first = c;
        tour_len   = 0;
      end else begin
        tour_len = add_sat(tour_len, dist_mat[tour_prev][c]);
      end
      tour_prev = c;
      tour_seen++;
      if (tour_seen >= city_count_cfg) begin
        total = add_sat(tour_len, dist_mat[c][tour_first]);
        fit   = (64'd1 << 40) / (total + FRAC_ONE);
        if (fit > 64'hFFFF_FFFF) fit = 64'hFFFF_FFFF;
        s.tour_length = total[LEN_W-1:0];
        s.fitness     = fit[FIT_W-1:0];
        expected_scores = {expected_scores, s};
        tour_seen = 0;
        tour_len  = 0;
      end
    end
  endtask

  function automatic logic [DIST_IN_W-1:0] rand_dist();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 27) return '1;
    if (r < 47) return DIST_IN_W'($urandom_range(0, 1023));
    return DIST_IN_W'($urandom);
  endfunction

  task automatic push_write(input int unsigned row, input int unsigned col,
                            input logic [DIST_IN_W-1:0] dist_val);
    tour_word_t w;
    w.opcode     = OP_WRITE;
    w.row_city   = CITY_W'(row);
    w.col_city   = CITY_W'(col);
    w.dist_value = dist_val;
    w.city       = CITY_W'($urandom);
    pending_words = {pending_words, w};
    plan_written[w.row_city][w.col_city] = 1'b1;
    words_planned++;
  endtask

  task automatic cover_leg(input logic [CITY_W-1:0] a, input logic [CITY_W-1:0] b);
    if (!plan_written[a][b]) push_write(a, b, rand_dist());
  endtask

  // write any leg the city will read before sending it
  task automatic push_city(input int unsigned city_idx);
    tour_word_t w;
    w.opcode     = OP_CITY;
    w.row_city   = CITY_W'($urandom);
    w.col_city   = CITY_W'($urandom);
    w.dist_value = DIST_IN_W'($urandom);
    w.city       = CITY_W'(city_idx);
    if (plan_seen == 0) plan_first = w.city;
    else cover_leg(plan_prev, w.city);
    plan_prev = w.city;
    plan_seen++;
    if (plan_seen >= city_count_cfg) begin
      cover_leg(w.city, plan_first);
      plan_seen = 0;
    end
    pending_words = {pending_words, w};
    words_planned++;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_ch.valid || expected_scores.size() != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_city_count(input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= COUNT_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
    city_count_cfg = (value < 2) ? 2 : (value > 64) ? 64 : value;
    in_burst  = ($urandom_range(0, 3) == 0);
    out_burst = ($urandom_range(0, 3) == 0);
  endtask

  task automatic random_phase(input int unsigned quota);
    int unsigned stop_at;
    int unsigned n;
    int unsigned j;
    int          order[64];
    int          swap;
    stop_at = words_planned + quota;
    while (words_planned < stop_at) begin
      n = city_count_cfg;
      for (int i = 0; i < 64; i++) order[i] = i;
      for (int i = n - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        swap     = order[i];
        order[i] = order[j];
        order[j] = swap;
      end
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0)
          push_write($urandom_range(0, 63), $urandom_range(0, 63), rand_dist());
        if ($urandom_range(0, 11) == 0) push_city($urandom_range(0, 63));
        else push_city(order[i]);
      end
    end
  endtask

  // near-max legs among a few cities push the length near, but not into, saturation
  task automatic saturating_phase();
    for (int a = 0; a < 8; a++) begin
      for (int b = 0; b < 8; b++) begin
        push_write(a, b, DIST_IN_W'(24'hFF_FFFF - $urandom_range(0, 15)));
      end
    end
    for (int i = 0; i < 128; i++) push_city($urandom_range(0, 7));
  endtask

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      score_word(cur_word);
      in_took = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_took = 1'b0;
    end else if (!in_ch.valid || in_took) begin
      in_took = 1'b0;
      if (in_gap > 0) begin
        in_ch.valid <= 1'b0;
        in_gap--;
      end else if (pending_words.size() != 0) begin
        cur_word = pending_words.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= cur_word.opcode;
        in_ch.row_city   <= cur_word.row_city;
        in_ch.col_city   <= cur_word.col_city;
        in_ch.dist_value <= cur_word.dist_value;
        in_ch.city       <= cur_word.city;
        in_gap = pick_gap(in_burst);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_ch.ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ch.ready <= 1'b1;
      if (!out_burst && $urandom_range(0, 5) == 0) ready_hold = pick_gap(1'b0);
    end
  end

  always @(posedge clk) begin
    tour_score_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_scores.size() == 0) begin
        report_fail($sformatf("unexpected result length %0d fitness %0d",
                              out_ch.tour_length, out_ch.fitness));
      end else begin
        want = expected_scores.pop_front();
        if (out_ch.tour_length !== want.tour_length)
          report_fail($sformatf("tour_length got %0d expected %0d",
                                out_ch.tour_length, want.tour_length));
        if (out_ch.fitness !== want.fitness)
          report_fail($sformatf("fitness got %0d expected %0d",
                                out_ch.fitness, want.fitness));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned cfg_seq[10] = '{65, 3, 127, 8, 1, 5, 64, 13, 2, 40};
    int unsigned phase;
    clk              = 1'b0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_WRITE;
    in_ch.row_city   = '0;
    in_ch.col_city   = '0;
    in_ch.dist_value = '0;
    in_ch.city       = '0;
    out_ch.ready     = 1'b0;
    fail_count       = 0;
    words_planned    = 0;
    city_count_cfg   = CITY_COUNT_RST;
    tour_seen        = 0;
    tour_first       = '0;
    tour_prev        = '0;
    tour_len         = 0;
    plan_seen        = 0;
    in_took          = 1'b0;
    in_gap           = 0;
    ready_hold       = 0;
    in_burst         = 1'b0;
    out_burst        = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // two-city tours: max legs, zero length, length of one LSB, high indices
    set_city_count(0);
    push_write(0, 63, '1);
    push_write(63, 0, '1);
    push_city(0);
    push_city(63);
    push_write(5, 5, '0);
    push_city(5);
    push_city(5);
    push_write(42, 21, 1);
    push_write(21, 42, 0);
    push_city(42);
    push_city(21);
    push_city(60);
    push_write(9, 9, 123);
    push_city(61);
    wait_idle();

    // lower the count in the middle of a tour
    set_city_count(4);
    push_city(3);
    push_city(10);
    push_city(20);
    wait_idle();
    set_city_count(1);
    push_city(30);
    wait_idle();

    phase = 0;
    while (words_planned < 1750) begin
      set_city_count(phase < 10 ? cfg_seq[phase] : $urandom_range(0, 127));
      random_phase($urandom_range(120, 220));
      wait_idle();
      if (phase == 1) begin
        set_city_count(64);
        saturating_phase();
        wait_idle();
      end
      phase++;
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
